### rtl/core/sortab_pkg.sv
// shared types, codes and controller/datapath interface structs for the sorted key table
package sortab_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] key;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_SHIFT,
        ST_MOVE,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic start;
        logic probe_rd;
        logic probe_upd;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_drop;
        logic lo_lt_hi;
        logic j_gt_lo;
        logic op_search;
        logic dropped;
        logic out_free;
    } ctrl_sts_t;

endpackage

### rtl/core/sortab_datapath.sv
// key memory, binary search bounds, shift pointer, count and result register
module sortab_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sortab_pkg::in_item_t s_item,
    input  sortab_pkg::ctrl_cmd_t cmd,
    output sortab_pkg::ctrl_sts_t sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sortab_pkg::out_item_t m_item
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [31:0] mem [TABLE_DEPTH];

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      j_reg, j_next;
    logic               op_reg, op_next;
    logic               drop_reg, drop_next;
    logic               hit_reg, hit_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] rd_data_reg;
    logic               m_valid_reg, m_valid_next;
    sortab_pkg::out_item_t m_item_reg, m_item_next;

    logic [CW-1:0]   mid;
    logic [CW-1:0]   j_m1;
    logic [IW-1:0]   rd_addr;
    logic            full;
    logic            inserted;
    logic [CW-1:0]   cnt_after;
    logic [CW+3:0]   pos_wide;
    logic [CW+4:0]   cnt_wide;

    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign j_m1 = j_reg - CW'(1);
    assign full = (count_reg >= CW'(TABLE_DEPTH));
    assign rd_addr = cmd.probe_rd ? mid[IW-1:0] : j_m1[IW-1:0];

    assign sts.in_drop   = (s_item.operation == sortab_pkg::OP_INSERT) && full;
    assign sts.lo_lt_hi  = (lo_reg < hi_reg);
    assign sts.j_gt_lo   = (j_reg > lo_reg);
    assign sts.op_search = (op_reg == sortab_pkg::OP_SEARCH);
    assign sts.dropped   = drop_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign inserted  = (op_reg == sortab_pkg::OP_INSERT) && !drop_reg;
    assign cnt_after = count_reg + (inserted ? CW'(1) : CW'(0));
    assign pos_wide  = {4'b0, lo_reg};
    assign cnt_wide  = {5'b0, cnt_after};

    always_comb begin
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        op_next      = op_reg;
        drop_next    = drop_reg;
        hit_next     = hit_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (cmd.start) begin
            key_next  = s_item.key;
            op_next   = s_item.operation;
            drop_next = sts.in_drop;
            lo_next   = '0;
            hi_next   = count_reg;
            j_next    = count_reg;
            hit_next  = 1'b0;
        end
        if (cmd.probe_upd) begin
            if (rd_data_reg < key_reg) begin
                lo_next = mid + CW'(1);
            end else begin
                hi_next  = mid;
                hit_next = (rd_data_reg == key_reg);
            end
        end
        if (cmd.shift_wr) begin
            j_next = j_m1;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next            = 1'b1;
            count_next              = cnt_after;
            m_item_next.entry_count = cnt_wide[4:0];
            m_item_next.position    = 4'd0;
            if (op_reg == sortab_pkg::OP_SEARCH) begin
                if (hit_reg) begin
                    m_item_next.status   = sortab_pkg::STATUS_FOUND;
                    m_item_next.position = pos_wide[3:0];
                end else begin
                    m_item_next.status = sortab_pkg::STATUS_NOT_FOUND;
                end
            end else if (drop_reg) begin
                m_item_next.status = sortab_pkg::STATUS_FULL;
            end else begin
                m_item_next.status   = sortab_pkg::STATUS_INSERTED;
                m_item_next.position = pos_wide[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        j_reg      <= j_next;
        op_reg     <= op_next;
        drop_reg   <= drop_next;
        hit_reg    <= hit_next;
        key_reg    <= key_next;
        m_item_reg <= m_item_next;
    end

    // key memory: one read, one write per cycle
    always_ff @(posedge aclk) begin
        if (cmd.probe_rd || cmd.shift_rd) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.ins_wr) begin
            mem[lo_reg[IW-1:0]] <= key_reg;
        end else if (cmd.shift_wr) begin
            mem[j_reg[IW-1:0]] <= rd_data_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### rtl/core/sortab_ctrl.sv
// sequencer for accept, binary search, shift-up insert and result hand-off
module sortab_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sortab_pkg::ctrl_sts_t sts,
    output sortab_pkg::ctrl_cmd_t cmd
);

    sortab_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sortab_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            sortab_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = sts.in_drop ? sortab_pkg::ST_RESPOND : sortab_pkg::ST_PROBE;
                end
            end
            sortab_pkg::ST_PROBE: begin
                if (sts.lo_lt_hi) begin
                    cmd.probe_rd = 1'b1;
                    state_next   = sortab_pkg::ST_COMPARE;
                end else if (sts.op_search) begin
                    state_next = sortab_pkg::ST_RESPOND;
                end else begin
                    state_next = sortab_pkg::ST_SHIFT;
                end
            end
            sortab_pkg::ST_COMPARE: begin
                cmd.probe_upd = 1'b1;
                state_next    = sortab_pkg::ST_PROBE;
            end
            sortab_pkg::ST_SHIFT: begin
                if (sts.j_gt_lo) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = sortab_pkg::ST_MOVE;
                end else begin
                    cmd.ins_wr = !sts.dropped;
                    state_next = sortab_pkg::ST_RESPOND;
                end
            end
            sortab_pkg::ST_MOVE: begin
                cmd.shift_wr = 1'b1;
                state_next   = sortab_pkg::ST_SHIFT;
            end
            sortab_pkg::ST_RESPOND: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = sortab_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sortab_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/sorted_table_insert_search.sv
// top level of the sorted key table with insert and search
//
//  channel  ports                      payload
//  s_       s_valid s_ready s_item     operation, key
//  m_       m_valid m_ready m_item     status, position, entry_count
//
// a search runs a binary search over the n stored keys between accept and result,
// each step issuing one memory read and one compare
// an insert adds a shift-up of the n - p keys above p, one read and one write per moved key
// a dropped insert into a full table goes from accept straight to the respond step
// reset clears the count; the key memory is never cleared
// the next item is accepted while a result waits in the output register; a stalled
// result holds the block in its respond step only when a second result is ready
module sorted_table_insert_search #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sortab_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sortab_pkg::out_item_t m_item
);

    sortab_pkg::ctrl_cmd_t cmd;
    sortab_pkg::ctrl_sts_t sts;

    sortab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sortab_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### rtl/core/sortab_checker.sv
// port-level checks for the sorted key table, bound to the top level
module sortab_checker #(
    parameter int DEPTH = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input sortab_pkg::out_item_t m_item
);

    localparam logic [4:0] FULL_COUNT = 5'(DEPTH);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == sortab_pkg::STATUS_FULL |-> m_item.entry_count == FULL_COUNT)
        else $error("dropped insert with table not full");

    a_miss_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == sortab_pkg::STATUS_NOT_FOUND ||
                    m_item.status == sortab_pkg::STATUS_FULL) |-> m_item.position == 4'd0)
        else $error("nonzero position on miss or drop");

    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

endmodule

bind sorted_table_insert_search sortab_checker #(
    .DEPTH (TABLE_DEPTH)
) u_sortab_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
